>>> rtl/hss_pkg.sv
// Shared types, constants and the half-step coil table for the stepper sequencer.
`timescale 1ns / 1ps

package hss_pkg;

    // Internal counter widths
    localparam int COUNT_BITS = 16;
    localparam int WAIT_BITS  = 8;

    // Field widths fixed by the port list
    localparam int STEP_W = 16;
    localparam int WAIT_W = 8;
    localparam int COIL_W = 4;

    // Word kinds on the action field
    localparam logic ACT_CMD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Classified input word, handed from front to back
    typedef struct packed {
        logic                         action;
        logic signed [COUNT_BITS-1:0] count;
        logic [WAIT_BITS-1:0]         reload;
        logic                         home_mode;
        logic                         released;
    } op_t;

    // Result word
    typedef struct packed {
        logic [COIL_W-1:0] coil;
        logic              busy;
        logic              stepped;
        logic              hstop;
    } res_t;

    // Half-step coil pattern for each of the eight phases
    function automatic logic [COIL_W-1:0] half_pattern(input logic [2:0] ph);
        logic [COIL_W-1:0] pat;
        begin
            unique case (ph)
                3'd0:    pat = 4'h1;
                3'd1:    pat = 4'h3;
                3'd2:    pat = 4'h2;
                3'd3:    pat = 4'h6;
                3'd4:    pat = 4'h4;
                3'd5:    pat = 4'hC;
                3'd6:    pat = 4'h8;
                default: pat = 4'h9;
            endcase
            return pat;
        end
    endfunction

endpackage

>>> rtl/hss_front.sv
// Front end: accepts input words, saturates and classifies them, queues them for the back end.
`timescale 1ns / 1ps

module hss_front
    import hss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               action,
    input  logic signed [15:0] step_count,
    input  logic [7:0]         wait_ticks,
    input  logic               home_mode,
    input  logic               home_switch,
    output logic               op_valid,
    output op_t                op,
    input  logic               op_take
);

    localparam logic signed [32:0] CNT_MAX = 33'((64'd1 << (COUNT_BITS - 1)) - 64'd1);
    localparam logic signed [32:0] CNT_MIN = -CNT_MAX - 33'sd1;
    localparam logic [16:0]        WT_MAX  = 17'((32'd1 << WAIT_BITS) - 32'd1);

    logic signed [32:0] cnt_wide;
    logic signed [32:0] cnt_sat;
    logic [16:0]        wt_wide;
    logic [16:0]        wt_sat;
    op_t                op_in;

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push_fire;
    logic       take_fire;

    // Saturate count and wait into the internal ranges; wait 0 runs as 1
    always_comb
    begin
        cnt_wide = 33'(step_count);
        if (cnt_wide > CNT_MAX)
            cnt_sat = CNT_MAX;
        else if (cnt_wide < CNT_MIN)
            cnt_sat = CNT_MIN;
        else
            cnt_sat = cnt_wide;

        wt_wide = {9'd0, wait_ticks};
        if (wt_wide > WT_MAX)
            wt_sat = WT_MAX;
        else if (wt_wide == 17'd0)
            wt_sat = 17'd1;
        else
            wt_sat = wt_wide;

        op_in.action    = action;
        op_in.count     = cnt_sat[COUNT_BITS-1:0];
        op_in.reload    = wt_sat[WAIT_BITS-1:0];
        op_in.home_mode = home_mode;
        op_in.released  = home_switch;
    end

    // Two-word queue toward the back end
    assign full      = (cnt_reg == 2'd2);
    assign push_fire = push && !full;
    assign op_valid  = (cnt_reg != 2'd0);
    assign take_fire = op_take && op_valid;
    assign op        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_fire;
        rd_ptr_next = rd_ptr_reg ^ take_fire;
        cnt_next    = cnt_reg + 2'(push_fire) - 2'(take_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wr_ptr_reg] <= op_in;
    end

endmodule

>>> rtl/hss_back.sv
// Back end: move state, step timing, coil latch and the result queue.
`timescale 1ns / 1ps

module hss_back
    import hss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  op_t         op,
    output logic        op_take,
    output logic        empty,
    input  logic        pop,
    output res_t        res
);

    logic [2:0]                  phase_reg, phase_next;
    logic signed [COUNT_BITS-1:0] steps_reg, steps_next;
    logic [WAIT_BITS-1:0]        tick_cnt_reg, tick_cnt_next;
    logic [WAIT_BITS-1:0]        tick_reload_reg, tick_reload_next;
    logic                        homing_reg, homing_next;
    logic                        moving_reg, moving_next;
    logic [COIL_W-1:0]           coil_reg, coil_next;

    logic                         op_fire;
    logic                         do_step;
    logic                         clear_steps;
    logic                         stepped_n;
    logic                         hstop_n;
    logic signed [COUNT_BITS-1:0] steps_base;
    logic [WAIT_BITS-1:0]         tc_dec;
    res_t                         res_in;

    res_t       rslot_reg [2];
    logic       rwr_ptr_reg, rwr_ptr_next;
    logic       rrd_ptr_reg, rrd_ptr_next;
    logic [1:0] rcnt_reg, rcnt_next;
    logic       pop_fire;

    // Take an op whenever the result queue has room
    assign pop_fire = pop && !empty;
    assign op_take  = (rcnt_reg != 2'd2) || pop_fire;
    assign op_fire  = op_take && op_valid;

    // Move state update for one word
    always_comb
    begin
        phase_next       = phase_reg;
        tick_cnt_next    = tick_cnt_reg;
        tick_reload_next = tick_reload_reg;
        homing_next      = homing_reg;
        moving_next      = moving_reg;
        coil_next        = coil_reg;
        do_step          = 1'b0;
        clear_steps      = 1'b0;
        hstop_n          = 1'b0;
        stepped_n        = 1'b0;
        steps_base       = steps_reg;
        tc_dec           = tick_cnt_reg;

        if (op_fire)
        begin
            if (op.action == ACT_CMD)
            begin
                // commands while busy are dropped
                if (!moving_reg)
                begin
                    homing_next      = op.home_mode;
                    tick_reload_next = op.reload;
                    steps_base       = op.count;
                    if (op.home_mode && op.released)
                    begin
                        hstop_n     = 1'b1;
                        clear_steps = 1'b1;
                    end
                    else
                    begin
                        do_step       = 1'b1;
                        tick_cnt_next = op.reload;
                        moving_next   = 1'b1;
                    end
                end
            end
            else if (moving_reg)
            begin
                if (tick_cnt_reg != '0)
                    tc_dec = tick_cnt_reg - 1'b1;
                tick_cnt_next = tc_dec;
                if (tc_dec == '0)
                begin
                    if (steps_reg == '0)
                        moving_next = 1'b0;
                    else if (homing_reg && op.released)
                    begin
                        moving_next = 1'b0;
                        hstop_n     = 1'b1;
                        clear_steps = 1'b1;
                    end
                    else
                    begin
                        do_step       = 1'b1;
                        tick_cnt_next = tick_reload_reg;
                    end
                end
            end
        end

        // One half step toward zero count
        steps_next = steps_base;
        if (do_step)
        begin
            stepped_n = (steps_base != '0);
            if (steps_base > 0)
            begin
                coil_next  = half_pattern(phase_reg);
                phase_next = phase_reg + 3'd1;
                steps_next = steps_base - 1'b1;
            end
            else if (steps_base < 0)
            begin
                coil_next  = half_pattern(phase_reg);
                phase_next = phase_reg - 3'd1;
                steps_next = steps_base + 1'b1;
            end
        end
        if (clear_steps)
            steps_next = '0;

        res_in.coil    = coil_next;
        res_in.busy    = moving_next;
        res_in.stepped = stepped_n;
        res_in.hstop   = hstop_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            steps_reg       <= '0;
            tick_cnt_reg    <= '0;
            tick_reload_reg <= '0;
            homing_reg      <= 1'b0;
            moving_reg      <= 1'b0;
            coil_reg        <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            steps_reg       <= steps_next;
            tick_cnt_reg    <= tick_cnt_next;
            tick_reload_reg <= tick_reload_next;
            homing_reg      <= homing_next;
            moving_reg      <= moving_next;
            coil_reg        <= coil_next;
        end
    end

    // Two-word result queue
    assign empty = (rcnt_reg == 2'd0);
    assign res   = rslot_reg[rrd_ptr_reg];

    always_comb
    begin
        rwr_ptr_next = rwr_ptr_reg ^ op_fire;
        rrd_ptr_next = rrd_ptr_reg ^ pop_fire;
        rcnt_next    = rcnt_reg + 2'(op_fire) - 2'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rwr_ptr_reg <= 1'b0;
            rrd_ptr_reg <= 1'b0;
            rcnt_reg    <= 2'd0;
        end
        else
        begin
            rwr_ptr_reg <= rwr_ptr_next;
            rrd_ptr_reg <= rrd_ptr_next;
            rcnt_reg    <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_fire)
            rslot_reg[rwr_ptr_reg] <= res_in;
    end

endmodule

>>> rtl/half_step_stepper_sequencer.sv
// Top level of the half-step unipolar stepper sequencer.
//
//   Channel   Handshake     Fields
//   -------   -----------   --------------------------------------------------
//   input     push / full   action, step_count, wait_ticks, home_mode, home_switch
//   result    pop / empty   coil_drive, busy_res, stepped, home_stop
//
// Each word (command or tick) gets one move-state update in the back end; one word per
// cycle is sustained while results are popped. A word that is pushed goes through the
// front queue, then through the move-state update into the result queue.
// Reset clears the move state, all coils off, and both two-word queues.
// A stalled result side fills the result queue, then the front queue, then
// raises full; no word is lost.
`timescale 1ns / 1ps

module half_step_stepper_sequencer
    import hss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               action,
    input  logic signed [15:0] step_count,
    input  logic [7:0]         wait_ticks,
    input  logic               home_mode,
    input  logic               home_switch,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         coil_drive,
    output logic               busy_res,
    output logic               stepped,
    output logic               home_stop
);

    logic op_valid;
    logic op_take;
    op_t  op;
    res_t res;

    // Classify and queue incoming words
    hss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .step_count  (step_count),
        .wait_ticks  (wait_ticks),
        .home_mode   (home_mode),
        .home_switch (home_switch),
        .op_valid    (op_valid),
        .op          (op),
        .op_take     (op_take)
    );

    // Carry out moves and queue results
    hss_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

    assign coil_drive = res.coil;
    assign busy_res   = res.busy;
    assign stepped    = res.stepped;
    assign home_stop  = res.hstop;

endmodule
